@@ hdl/dbs_pkg.sv @@
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared types and constants of the double buffered bit serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package dbs_pkg;

  // field widths
  localparam int FuncW      = 2;
  localparam int PayloadW   = 64;
  localparam int CountW     = 7;
  localparam int DurW       = 32;
  localparam int BitPeriodW = 16;
  localparam int InDataW    = 72;   // payload + bit_count, padded to bytes
  localparam int OutDataW   = 40;   // line, request, duration, standby, padded

  // configuration port
  localparam int CfgDataW = 32;
  localparam int CfgAddrW = 3;
  localparam logic RegBitPeriod = 1'b0;  // register index taken from paddr[2]
  localparam logic [BitPeriodW-1:0] BitPeriodReset = 16'd10;

  // defaults of the top level parameters
  localparam int MaxBitsDef    = 64;
  localparam int QueueDepthDef = 2;

  // func codes on the input channel
  localparam logic [FuncW-1:0] FuncLoad    = 2'd0;
  localparam logic [FuncW-1:0] FuncStandby = 2'd1;
  localparam logic [FuncW-1:0] FuncTick    = 2'd2;
  localparam logic [FuncW-1:0] FuncUnused  = 2'd3;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_STANDBY,
    OP_TICK,
    OP_NONE
  } dbs_op_t;

  typedef enum logic [1:0] {
    ST_STOPPED,   // idle, waits for a load
    ST_ARMED,     // loaded, waiting for the first tick
    ST_SENDING
  } dbs_state_t;

  // classified item, front to back
  typedef struct packed {
    dbs_op_t               op;
    logic [PayloadW-1:0]   payload;
    logic [CountW-1:0]     bit_count;  // already clamped to MAX_BITS
    logic                  end_mark;
  } dbs_item_t;

  typedef struct packed {
    logic                line_level;
    logic                request_next;
    logic                finished;
    logic [DurW-1:0]     duration;
    logic                standby_done;
  } dbs_result_t;

endpackage

@@ hdl/double_buffered_bit_serializer.sv @@
// ----------------------------------------------------------------------------
// double_buffered_bit_serializer
// On-off keying serializer with a ping-pong pair of word buffers.
// ----------------------------------------------------------------------------
// Usage:
//  - in_* stream: each transfer is one command. in_tuser is func (load word,
//    standby, one tick), in_tlast the end-of-transmission mark, in_tdata the
//    word bits and its bit count.
//  - out_* stream: exactly one result transfer per input transfer, in order:
//    line level after the command, the next-word request pulse, the finish
//    pulse (on out_tlast) with the saturating tick count, and the standby ack.
//  - cfg_* APB port: bit_period at byte address 0, ticks each bit is held
//    (0 acts as 1). Write it only while the block is idle.
//  - An input transfer is written into the item queue, then taken by the back
//    end into its registered result stage. One command per cycle is sustained
//    while the receiver keeps out_tready high.
//  - A stalled receiver fills the result register, then the queue; in_tready
//    drops only when the queue is full, and nothing is dropped.
//  - Reset clears all control state and sets bit_period to 10. The word
//    buffers are not cleared; they are written by load commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module double_buffered_bit_serializer #(
  parameter int MAX_BITS    = dbs_pkg::MaxBitsDef,    // longest word, 1..64
  parameter int QUEUE_DEPTH = dbs_pkg::QueueDepthDef  // front/back queue, >= 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input stream
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [63:0] payload, [70:64] bit_count, [71] zero
  input  logic [dbs_pkg::InDataW-1:0]   in_tdata,
  // [1:0] func
  input  logic [dbs_pkg::FuncW-1:0]     in_tuser,
  input  logic                          in_tlast,   // end_mark
  // result stream
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] line_level, [1] request_next, [33:2] duration, [34] standby_done,
  // [39:35] zero
  output logic [dbs_pkg::OutDataW-1:0]  out_tdata,
  output logic                          out_tlast,  // finished
  // configuration
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [dbs_pkg::CfgAddrW-1:0]  cfg_paddr,
  input  logic [dbs_pkg::CfgDataW-1:0]  cfg_pwdata,
  output logic [dbs_pkg::CfgDataW-1:0]  cfg_prdata,
  output logic                          cfg_pready
);

  localparam int PW = dbs_pkg::BitPeriodW;

  logic [PW-1:0] bit_period_r;

  dbs_pkg::dbs_item_t   front_item, head_item;
  dbs_pkg::dbs_result_t res;
  logic                 q_can_push, q_can_pop, q_pop;
  logic                 cfg_wr;
  logic                 reg_sel;

  // ---- configuration: one register, index from paddr[2]
  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (reg_sel == dbs_pkg::RegBitPeriod) ?
                      dbs_pkg::CfgDataW'(bit_period_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_period_r <= dbs_pkg::BitPeriodReset;
    end else if (cfg_wr && (reg_sel == dbs_pkg::RegBitPeriod)) begin
      bit_period_r <= cfg_pwdata[PW-1:0];
    end
  end

  // ---- front: classify each transfer
  dbs_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .func     (in_tuser),
    .data     (in_tdata),
    .end_mark (in_tlast),
    .item     (front_item)
  );

  assign in_tready = q_can_push;

  // ---- queue between front and back
  dbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_tvalid),
    .push_item (front_item),
    .can_push  (q_can_push),
    .pop       (q_pop),
    .can_pop   (q_can_pop),
    .head      (head_item)
  );

  // ---- back: buffers, bit timing, result register
  dbs_back #(
    .MAX_BITS (MAX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .bit_period (bit_period_r),
    .item_valid (q_can_pop),
    .item       (head_item),
    .item_take  (q_pop),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res        (res)
  );

  assign out_tdata = {5'b0, res.standby_done, res.duration,
                      res.request_next, res.line_level};
  assign out_tlast = res.finished;

endmodule

@@ hdl/dbs_front.sv @@
// ----------------------------------------------------------------------------
// dbs_front
// Unpacks input transfers, decodes func and clamps the bit count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbs_front #(
  parameter int MAX_BITS = dbs_pkg::MaxBitsDef
) (
  input  logic [dbs_pkg::FuncW-1:0]   func,
  input  logic [dbs_pkg::InDataW-1:0] data,
  input  logic                        end_mark,
  output dbs_pkg::dbs_item_t          item
);

  localparam logic [dbs_pkg::CountW-1:0] MaxCount = dbs_pkg::CountW'(MAX_BITS);

  logic [dbs_pkg::CountW-1:0] count_raw;

  assign count_raw = data[dbs_pkg::PayloadW +: dbs_pkg::CountW];

  always_comb begin
    unique case (func)
      dbs_pkg::FuncLoad:    item.op = dbs_pkg::OP_LOAD;
      dbs_pkg::FuncStandby: item.op = dbs_pkg::OP_STANDBY;
      dbs_pkg::FuncTick:    item.op = dbs_pkg::OP_TICK;
      dbs_pkg::FuncUnused:  item.op = dbs_pkg::OP_NONE;
      default:              item.op = dbs_pkg::OP_NONE;
    endcase
    item.payload   = data[dbs_pkg::PayloadW-1:0];
    item.bit_count = (count_raw > MaxCount) ? MaxCount : count_raw;
    item.end_mark  = end_mark;
  end

endmodule

@@ hdl/dbs_queue.sv @@
// ----------------------------------------------------------------------------
// dbs_queue
// Small flop-based FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbs_queue #(
  parameter int DEPTH = dbs_pkg::QueueDepthDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  dbs_pkg::dbs_item_t push_item,
  output logic               can_push,
  input  logic               pop,
  output logic               can_pop,
  output dbs_pkg::dbs_item_t head
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  dbs_pkg::dbs_item_t entry_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic            do_push, do_pop;

  assign can_push = (count_r != Full);
  assign can_pop  = (count_r != '0);
  assign do_push  = push && can_push;
  assign do_pop   = pop && can_pop;
  assign head     = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

@@ hdl/dbs_back.sv @@
// ----------------------------------------------------------------------------
// dbs_back
// Ping-pong word buffers, bit timing, and the registered result stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbs_back #(
  parameter int MAX_BITS = dbs_pkg::MaxBitsDef
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [dbs_pkg::BitPeriodW-1:0] bit_period,
  input  logic                           item_valid,
  input  dbs_pkg::dbs_item_t             item,
  output logic                           item_take,
  output logic                           res_valid,
  input  logic                           res_ready,
  output dbs_pkg::dbs_result_t           res
);

  localparam int LenW = $clog2(MAX_BITS + 1);
  localparam int IdxW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int PW   = dbs_pkg::BitPeriodW;
  localparam int DW   = dbs_pkg::DurW;
  localparam logic [LenW-1:0] MaxPos = LenW'(MAX_BITS);

  // word buffers, no reset (undefined until loaded)
  logic [MAX_BITS-1:0] word_r [2];
  logic [LenW-1:0]     len_r  [2];
  logic                end_r  [2];

  dbs_pkg::dbs_state_t state_r, state_nxt;
  logic            act_r, act_nxt;
  logic [LenW-1:0] pos_r, pos_nxt;
  logic [PW-1:0]   hold_r, hold_nxt;
  logic            reqd_r, reqd_nxt;
  logic [DW-1:0]   elapsed_r, elapsed_nxt;
  logic            line_r, line_nxt;

  logic                 res_valid_r;
  dbs_pkg::dbs_result_t res_r, res_nxt;

  logic fire;
  logic wr_en, wr_sel;

  assign item_take = item_valid && (!res_valid_r || res_ready);
  assign fire      = item_take;
  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_comb begin
    logic [PW-1:0]       period;
    logic                a;
    logic [LenW-1:0]     p;
    logic [PW-1:0]       h;
    logic                rq;
    logic [DW-1:0]       e;
    logic [MAX_BITS-1:0] w;
    logic [LenW-1:0]     len_a;

    state_nxt   = state_r;
    act_nxt     = act_r;
    pos_nxt     = pos_r;
    hold_nxt    = hold_r;
    reqd_nxt    = reqd_r;
    elapsed_nxt = elapsed_r;
    line_nxt    = line_r;
    res_nxt     = '0;
    wr_en       = 1'b0;
    wr_sel      = 1'b0;
    period      = (bit_period == '0) ? PW'(1) : bit_period;
    a           = act_r;
    p           = pos_r;
    h           = hold_r;
    rq          = reqd_r;
    e           = elapsed_r;
    w           = '0;
    len_a       = '0;

    if (fire) begin
      unique case (item.op)
        dbs_pkg::OP_LOAD: begin
          wr_en  = 1'b1;
          wr_sel = (state_r == dbs_pkg::ST_SENDING) ? ~act_r : 1'b0;
          if (state_r == dbs_pkg::ST_STOPPED) begin
            state_nxt = dbs_pkg::ST_ARMED;
          end
        end
        dbs_pkg::OP_STANDBY: begin
          state_nxt            = dbs_pkg::ST_STOPPED;
          act_nxt              = 1'b0;
          pos_nxt              = '0;
          hold_nxt             = '0;
          reqd_nxt             = 1'b0;
          elapsed_nxt          = '0;
          line_nxt             = 1'b0;
          res_nxt.standby_done = 1'b1;
        end
        dbs_pkg::OP_TICK: begin
          if (state_r != dbs_pkg::ST_STOPPED) begin
            if (state_r == dbs_pkg::ST_ARMED) begin
              a  = 1'b0;
              p  = '0;
              h  = '0;
              rq = 1'b0;
              e  = '0;
            end else if (e != '1) begin
              e = e + DW'(1);
            end
            if (a ? end_r[1] : end_r[0]) begin
              // end word: stop and report
              res_nxt.finished = 1'b1;
              res_nxt.duration = e;
              state_nxt        = dbs_pkg::ST_STOPPED;
              a                = 1'b0;
              p                = '0;
              h                = '0;
              rq               = 1'b0;
              line_nxt         = 1'b0;
            end else begin
              state_nxt = dbs_pkg::ST_SENDING;
              if (h >= period) begin
                h = '0;
                if (p < MaxPos) begin
                  p = p + LenW'(1);
                end
              end
              len_a = a ? len_r[1] : len_r[0];
              if (p >= len_a) begin
                // word done: swap buffers
                a  = ~a;
                p  = '0;
                h  = '0;
                rq = 1'b0;
              end
              if (!(a ? end_r[1] : end_r[0])) begin
                len_a = a ? len_r[1] : len_r[0];
                w     = a ? word_r[1] : word_r[0];
                if (p < len_a) begin
                  line_nxt = w[p[IdxW-1:0]];
                  h        = h + PW'(1);
                  if (!rq) begin
                    rq                   = 1'b1;
                    res_nxt.request_next = 1'b1;
                  end
                end else begin
                  line_nxt = 1'b0;
                end
              end
            end
            act_nxt     = a;
            pos_nxt     = p;
            hold_nxt    = h;
            reqd_nxt    = rq;
            elapsed_nxt = e;
          end
        end
        dbs_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
    res_nxt.line_level = line_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dbs_pkg::ST_STOPPED;
      act_r       <= 1'b0;
      pos_r       <= '0;
      hold_r      <= '0;
      reqd_r      <= 1'b0;
      elapsed_r   <= '0;
      line_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      act_r     <= act_nxt;
      pos_r     <= pos_nxt;
      hold_r    <= hold_nxt;
      reqd_r    <= reqd_nxt;
      elapsed_r <= elapsed_nxt;
      line_r    <= line_nxt;
      if (fire) begin
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
    if (wr_en) begin
      word_r[wr_sel] <= item.payload[MAX_BITS-1:0];
      len_r[wr_sel]  <= item.bit_count[LenW-1:0];
      end_r[wr_sel]  <= item.end_mark;
    end
  end

endmodule

@@ hdl/dbs_checker.sv @@
// ----------------------------------------------------------------------------
// dbs_checker
// Port-level assertions for the serializer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module dbs_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [dbs_pkg::OutDataW-1:0]  out_tdata,
  input logic                          out_tlast
);

  // held result does not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // finish drives the line low and carries no other pulse
  a_finish_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[0] && !out_tdata[1] && !out_tdata[34])
    else $error("finish result carries line or pulses");

  // duration is zero unless finished
  a_dur_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[33:2] == 32'd0)
    else $error("duration set without finish");

  // standby ack: line low, no request
  a_standby_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[34] |-> !out_tdata[0] && !out_tdata[1])
    else $error("standby result carries line or request");

  // no result right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind double_buffered_bit_serializer dbs_checker u_dbs_checker (.*);

@@ tb/tb_double_buffered_bit_serializer.sv @@
// ----------------------------------------------------------------------------
// tb_double_buffered_bit_serializer
// Self-checking bench for the ping-pong on-off keying serializer: commands
// go in on the in_* stream, every result transfer is checked field by field
// against a cycle-free model of the line, request, finish and standby logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_double_buffered_bit_serializer;

  localparam int MaxBits = dbs_pkg::MaxBitsDef;
  localparam int StallLimit = 2000;     // cycles without any transfer
  localparam int DrainPad = 4;          // margin after the last result is taken
  localparam int HoldOffCycles = 60;    // long receiver stall, fills the queue
  localparam logic [dbs_pkg::CfgAddrW-1:0] BitPeriodAddr = {dbs_pkg::RegBitPeriod, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_tvalid = 1'b0;
  logic in_tready;
  // [63:0] payload, [70:64] bit_count, [71] zero
  logic [dbs_pkg::InDataW-1:0] in_tdata = '0;
  logic [dbs_pkg::FuncW-1:0] in_tuser = dbs_pkg::FuncTick; // [1:0] func
  logic in_tlast = 1'b0;                // end_mark

  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [dbs_pkg::OutDataW-1:0] out_tdata; // [0] line, [1] request, [33:2] duration,
                                           // [34] standby_done
  logic out_tlast;                      // finished

  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [dbs_pkg::CfgAddrW-1:0] cfg_paddr = '0;
  logic [dbs_pkg::CfgDataW-1:0] cfg_pwdata = '0;
  logic [dbs_pkg::CfgDataW-1:0] cfg_prdata;
  logic cfg_pready;

  always #1 clk = ~clk;

  double_buffered_bit_serializer dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .in_tlast(in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Line model: own copy of the register, the two word buffers and the
  // transmit control state. Updated once per accepted command transfer.
  // --------------------------------------------------------------------------
  logic [dbs_pkg::BitPeriodW-1:0] bit_period_q = dbs_pkg::BitPeriodReset;
  logic [dbs_pkg::PayloadW-1:0] buf_word [2];
  logic [dbs_pkg::CountW-1:0] buf_len [2];
  logic buf_end [2];
  logic tx_running = 1'b0;
  logic tx_started = 1'b0;
  logic tx_active = 1'b0;
  logic [dbs_pkg::CountW-1:0] tx_bit_pos = '0;
  logic [dbs_pkg::BitPeriodW-1:0] tx_hold = '0;
  logic tx_requested = 1'b0;
  logic [dbs_pkg::DurW-1:0] tx_elapsed = '0;
  logic tx_line = 1'b0;

  dbs_pkg::dbs_result_t pending_line_results[$];  // one per accepted command, in order
  dbs_pkg::dbs_result_t latest_prediction;
  int mismatches = 0;
  int send_gap_max = 6;
  int recv_stall_max = 6;
  int hold_off_request = 0;              // picked up by the receiver process

  function automatic logic [dbs_pkg::CountW-1:0] clamped_len(
      logic [dbs_pkg::CountW-1:0] n);
    return (n > dbs_pkg::CountW'(MaxBits)) ? dbs_pkg::CountW'(MaxBits) : n;
  endfunction

  // standby, and the finish of an end word, drop all control state
  task automatic clear_tx_state();
    tx_running = 1'b0;
    tx_started = 1'b0;
    tx_active = 1'b0;
    tx_bit_pos = '0;
    tx_hold = '0;
    tx_requested = 1'b0;
    tx_elapsed = '0;
    tx_line = 1'b0;
  endtask

  task automatic predict_line_result(input logic [dbs_pkg::FuncW-1:0] func,
                                     input logic [dbs_pkg::PayloadW-1:0] payload,
                                     input logic [dbs_pkg::CountW-1:0] count,
                                     input logic end_mark,
                                     output dbs_pkg::dbs_result_t res);
    logic [dbs_pkg::BitPeriodW-1:0] period;
    logic target;
    res = '0;
    period = (bit_period_q == '0) ? dbs_pkg::BitPeriodW'(1) : bit_period_q;
    if (func == dbs_pkg::FuncLoad) begin
      // load fills the idle half; buffer 0 until the first tick took it
      target = tx_started ? ~tx_active : 1'b0;
      buf_word[target] = payload;
      buf_len[target] = count;
      buf_end[target] = end_mark;
      tx_running = 1'b1;
    end else if (func == dbs_pkg::FuncStandby) begin
      clear_tx_state();
      res.standby_done = 1'b1;
    end else if (func == dbs_pkg::FuncTick && tx_running) begin
      if (!tx_started) begin
        tx_started = 1'b1;
        tx_active = 1'b0;
        tx_bit_pos = '0;
        tx_hold = '0;
        tx_requested = 1'b0;
        tx_elapsed = '0;
      end else if (tx_elapsed != '1) begin
        tx_elapsed = tx_elapsed + dbs_pkg::DurW'(1);   // saturating tick count
      end
      if (buf_end[tx_active]) begin
        res.finished = 1'b1;
        res.duration = tx_elapsed;
        clear_tx_state();
      end else begin
        if (tx_hold >= period) begin
          tx_hold = '0;
          if (tx_bit_pos < dbs_pkg::CountW'(MaxBits)) begin
            tx_bit_pos = tx_bit_pos + dbs_pkg::CountW'(1);
          end
        end
        // word done (or empty): swap halves and re-arm the request
        if (tx_bit_pos >= clamped_len(buf_len[tx_active])) begin
          tx_active = ~tx_active;
          tx_bit_pos = '0;
          tx_hold = '0;
          tx_requested = 1'b0;
        end
        // an end word reached by the swap is only acted on at the next tick
        if (!buf_end[tx_active]) begin
          if (tx_bit_pos < clamped_len(buf_len[tx_active])) begin
            tx_line = buf_word[tx_active][tx_bit_pos[5:0]];
            tx_hold = tx_hold + dbs_pkg::BitPeriodW'(1);
            if (!tx_requested) begin
              tx_requested = 1'b1;
              res.request_next = 1'b1;
            end
          end else begin
            tx_line = 1'b0;
          end
        end
      end
    end
    res.line_level = tx_line;
  endtask

  // --------------------------------------------------------------------------
  // Command sender: per-transfer random gap, tvalid held until accepted.
  // --------------------------------------------------------------------------
  task automatic send_item(logic [dbs_pkg::FuncW-1:0] func,
                           logic [dbs_pkg::PayloadW-1:0] payload,
                           logic [dbs_pkg::CountW-1:0] count, logic end_mark);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= func;
    in_tdata <= {1'b0, count, payload};
    in_tlast <= end_mark;
    do @(posedge clk); while (!in_tready);
    predict_line_result(func, payload, count, end_mark, latest_prediction);
    pending_line_results.push_back(latest_prediction);
  endtask

  // drops tvalid and always waits on the clock before returning, so a following send
  // never lowers and raises tvalid in the same step
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_line_results.size() != 0);
    repeat (DrainPad) @(posedge clk);
  endtask

  function automatic logic [dbs_pkg::PayloadW-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // mostly short words so that buffer swaps are frequent
  function automatic logic [dbs_pkg::CountW-1:0] pick_word_length();
    int roll;
    roll = $urandom_range(99, 0);
    if (roll < 80) return dbs_pkg::CountW'($urandom_range(8, 1));
    if (roll < 88) return '0;
    if (roll < 96) return dbs_pkg::CountW'($urandom_range(MaxBits, 9));
    return dbs_pkg::CountW'($urandom_range(127, MaxBits + 1));
  endfunction

  task automatic send_random_word(logic end_mark);
    send_item(dbs_pkg::FuncLoad, random_word(), pick_word_length(), end_mark);
  endtask

  task automatic send_tick();
    send_item(dbs_pkg::FuncTick, random_word(), dbs_pkg::CountW'($urandom),
              1'($urandom));
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // APB write of bit_period while idle, followed by a read-back
  task automatic program_bit_period(logic [dbs_pkg::BitPeriodW-1:0] value);
    wait_drained();
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= BitPeriodAddr;
    cfg_pwdata <= {16'($urandom), value};   // upper bits are not part of the register
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    bit_period_q = value;
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    check_field("bit_period", 32'(value), 32'(cfg_prdata[dbs_pkg::BitPeriodW-1:0]));
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Well-formed transmissions: a first word, ticks, the next word loaded on
  // most requests, an end word after a few; sprinkled with stray commands.
  task automatic run_transmissions(int item_budget);
    int sent;
    int words_left;
    int roll;
    sent = 0;
    while (sent < item_budget) begin
      words_left = $urandom_range(4, 0);
      send_random_word(1'b0);
      sent++;
      do begin
        roll = $urandom_range(99, 0);
        if (roll < 3) begin
          send_item(dbs_pkg::FuncUnused, random_word(), dbs_pkg::CountW'($urandom),
                    1'($urandom));
        end else if (roll < 4) begin
          send_item(dbs_pkg::FuncStandby, random_word(), dbs_pkg::CountW'($urandom),
                    1'($urandom));
        end else if (roll < 6) begin
          send_random_word(1'($urandom_range(3, 0) == 0));   // idle half, else buffer 0
        end else begin
          send_tick();
          if (latest_prediction.request_next && $urandom_range(9, 0) != 0) begin
            sent++;
            send_random_word(words_left <= 0);
            words_left--;
          end
        end
        sent++;
      end while (!latest_prediction.finished && !latest_prediction.standby_done &&
                 sent < item_budget);
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_idle_commands();
    send_item(dbs_pkg::FuncTick, '0, '0, 1'b0);           // tick while stopped
    send_item(dbs_pkg::FuncUnused, '1, '1, 1'b1);         // unused func code
    send_item(dbs_pkg::FuncStandby, '1, '0, 1'b0);
    send_item(dbs_pkg::FuncTick, '1, '1, 1'b1);
  endtask

  // Both halves get loaded here, before anything can swap into buffer 1.
  task automatic test_word_extremes();
    send_item(dbs_pkg::FuncLoad, '1, dbs_pkg::CountW'(MaxBits), 1'b0);
    send_item(dbs_pkg::FuncTick, '0, '0, 1'b0);
    send_item(dbs_pkg::FuncLoad, '0, '1, 1'b0);           // overlong bit count
    send_item(dbs_pkg::FuncUnused, '0, '0, 1'b0);         // ignored while running
    send_item(dbs_pkg::FuncTick, '1, '1, 1'b1);
    send_item(dbs_pkg::FuncStandby, '0, '0, 1'b1);
    send_item(dbs_pkg::FuncTick, '0, '0, 1'b0);
  endtask

  task automatic test_empty_and_end_words();
    program_bit_period('0);                      // zero period acts as one
    send_item(dbs_pkg::FuncLoad, 64'h5, 7'd3, 1'b0);
    send_tick();
    send_item(dbs_pkg::FuncLoad, '1, '0, 1'b0);           // empty word in the idle half
    repeat (3) send_tick();
    send_item(dbs_pkg::FuncLoad, 64'h2, 7'd2, 1'b0);
    send_tick();
    send_item(dbs_pkg::FuncLoad, '1, dbs_pkg::CountW'(MaxBits), 1'b1);
    do send_tick(); while (!latest_prediction.finished);
    send_item(dbs_pkg::FuncLoad, random_word(), 7'd5, 1'b1);  // end word as the first word
    send_tick();
  endtask

  task automatic test_bit_period_settings();
    program_bit_period(dbs_pkg::BitPeriodW'(1));
    send_gap_max = 0;                            // back-to-back on both sides
    recv_stall_max = 0;
    run_transmissions(300);
    send_gap_max = 6;
    recv_stall_max = 6;
    run_transmissions(250);
    program_bit_period('1);                      // longest hold: bits never advance
    run_transmissions(60);
    program_bit_period(dbs_pkg::BitPeriodW'(2));
    run_transmissions(350);
    program_bit_period(dbs_pkg::BitPeriodW'(3));
    send_gap_max = 2;
    run_transmissions(300);
    program_bit_period(dbs_pkg::BitPeriodW'($urandom_range(8, 4)));
    send_gap_max = 6;
    recv_stall_max = 2;
    run_transmissions(250);
    recv_stall_max = 6;
  endtask

  // receiver stops for a long while, sender keeps pushing until tready drops
  task automatic test_back_pressure();
    program_bit_period(dbs_pkg::BitPeriodW'(1));
    send_gap_max = 0;
    hold_off_request = HoldOffCycles;
    run_transmissions(60);
    send_gap_max = 6;
    wait_drained();
  endtask

  task automatic test_random_commands();
    program_bit_period(dbs_pkg::BitPeriodW'(2));
    repeat (200) begin
      send_item(dbs_pkg::FuncW'($urandom_range(3, 0)), random_word(),
                dbs_pkg::CountW'($urandom), 1'($urandom));
    end
  endtask

  // --------------------------------------------------------------------------
  // Result receiver: random stall before each transfer, long hold-off on
  // request (counted here, independent of the sender).
  // --------------------------------------------------------------------------
  initial begin : result_receiver
    int stall;
    @(posedge clk);
    forever begin
      stall = $urandom_range(recv_stall_max, 0);
      if (hold_off_request != 0) begin
        stall = hold_off_request;
        hold_off_request = 0;
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // every result transfer against the oldest prediction
  always @(posedge clk) begin : result_check
    dbs_pkg::dbs_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_line_results.size() == 0) begin
        $error("result transfer with no command outstanding");
        mismatches++;
      end else begin
        want = pending_line_results.pop_front();
        check_field("line_level", 32'(want.line_level), 32'(out_tdata[0]));
        check_field("request_next", 32'(want.request_next), 32'(out_tdata[1]));
        check_field("finished", 32'(want.finished), 32'(out_tlast));
        check_field("duration", want.duration, out_tdata[33:2]);
        check_field("standby_done", 32'(want.standby_done), 32'(out_tdata[34]));
      end
    end
  end

  // ends a hung run: no transfer on either stream for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("double_buffered_bit_serializer: mismatch");
    $finish;
  end

  initial begin : test_sequence
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_commands();
    test_word_extremes();
    test_empty_and_end_words();
    test_bit_period_settings();
    test_back_pressure();
    test_random_commands();
    wait_drained();
    if (mismatches == 0) begin
      $display("double_buffered_bit_serializer: match");
    end else begin
      $display("double_buffered_bit_serializer: mismatch");
    end
    $finish;
  end

endmodule
